// File: rtl/core/lsf_pkg.sv
// Shared constants, types and a helper function for the five-point line fit.
package lsf_pkg;

  localparam int NPTS  = 5;              // points per channel
  localparam int CH_W  = 4;              // channel tag width
  localparam int VW    = 24;             // Q12.12 sample width
  localparam int SW    = 27;             // width of sum of five samples
  localparam int PW    = 2 * VW;         // single product width
  localparam int PSW   = PW + 3;         // sum of five products
  localparam int NW    = 56;             // signed numerator / denominator
  localparam int MW    = NW - 1;         // magnitudes
  localparam int FRAC  = 16;             // Q16.16 fraction bits
  localparam int QI    = 16;             // integer quotient bits before overflow
  localparam int QB    = QI + FRAC + 1;  // quotient bits incl. round bit
  localparam int SLW   = 32;             // result width
  localparam int XW    = SW + SLW + 2;   // intercept numerator in 2^-28 units
  localparam int RSH   = 12;             // 2^-28 -> 2^-16
  localparam int TW    = 36;             // intercept dividend after shift
  localparam int NDIG  = TW / 4;         // hex digits in the divide by five
  localparam int DPS   = 3;              // digits per stage
  localparam int SUM_STAGES  = 5;
  localparam int TAIL_STAGES = 9;
  localparam int LAT   = SUM_STAGES + QB + TAIL_STAGES;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DEGEN = 2'd1;
  localparam logic [1:0] ST_SAT   = 2'd2;

  localparam logic signed [SLW-1:0] SAT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [SLW-1:0] SAT_MIN = 32'sh8000_0000;

  typedef logic signed [VW-1:0] smp_t;
  typedef logic signed [SW-1:0] sum_t;

  typedef struct packed {
    logic [CH_W-1:0] channel;
    sum_t            sv;
    sum_t            su;
    logic            degen;
    logic            neg;
    logic            ovf;
  } ctx_t;

  // one base-16 digit of a divide by five: val < 80, returns {quotient, remainder}
  function automatic logic [6:0] div5_step(input logic [6:0] val);
    logic [3:0] q;
    logic [6:0] r;
    q = '0;
    for (int i = 1; i < 16; i++) begin
      if (val >= 7'(NPTS * i)) q = 4'(i);
    end
    r = val - 7'(NPTS * q);
    return {q, r[2:0]};
  endfunction

endpackage

// File: rtl/core/lsf_sums.sv
// Product and sum stages: forms numerator and denominator magnitudes of the slope.
module lsf_sums import lsf_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  logic [CH_W-1:0] channel_i,
  input  smp_t            volt_i [NPTS],
  input  smp_t            unit_i [NPTS],
  output logic            valid_o,
  output logic [MW-1:0]   n_o,
  output logic [MW-1:0]   d_o,
  output ctx_t            ctx_o
);

  logic [SUM_STAGES-1:0] vld_q;

  logic signed [PW-1:0] pvu_q [NPTS];
  logic signed [PW-1:0] pvv_q [NPTS];
  sum_t sv1_q, su1_q, sv1_d, su1_d;
  logic [CH_W-1:0] ch1_q, ch2_q, ch3_q, ch4_q;

  logic signed [PSW-1:0] svu2_q, svv2_q, svu2_d, svv2_d;
  sum_t sv2_q, su2_q, sv3_q, su3_q, sv4_q, su4_q;

  logic signed [NW-1:0]     svu5_q, svv5_q;
  logic signed [2*SW-1:0]   svsu3_q, svsv3_q;
  logic signed [NW-1:0]     num4_q, den4_q;

  logic [MW-1:0] n_q, d_q, n_d, d_d;
  ctx_t          ctx_q, ctx_d;

  always_comb begin
    sv1_d = '0;
    su1_d = '0;
    for (int i = 0; i < NPTS; i++) begin
      sv1_d = sv1_d + SW'(volt_i[i]);
      su1_d = su1_d + SW'(unit_i[i]);
    end
  end

  always_comb begin
    svu2_d = '0;
    svv2_d = '0;
    for (int i = 0; i < NPTS; i++) begin
      svu2_d = svu2_d + PSW'(pvu_q[i]);
      svv2_d = svv2_d + PSW'(pvv_q[i]);
    end
  end

  always_comb begin
    logic neg;
    neg       = num4_q[NW-1];
    n_d       = neg ? MW'(-num4_q) : MW'(num4_q);
    d_d       = MW'(den4_q);
    ctx_d.channel = ch4_q;
    ctx_d.sv      = sv4_q;
    ctx_d.su      = su4_q;
    ctx_d.degen   = (den4_q <= 0);
    ctx_d.neg     = neg;
    ctx_d.ovf     = ((n_d >> FRAC) >= d_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[SUM_STAGES-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    // stage 1: products and plain sums
    for (int i = 0; i < NPTS; i++) begin
      pvu_q[i] <= volt_i[i] * unit_i[i];
      pvv_q[i] <= volt_i[i] * volt_i[i];
    end
    sv1_q <= sv1_d;
    su1_q <= su1_d;
    ch1_q <= channel_i;
    // stage 2: product sums
    svu2_q <= svu2_d;
    svv2_q <= svv2_d;
    sv2_q  <= sv1_q;
    su2_q  <= su1_q;
    ch2_q  <= ch1_q;
    // stage 3: cross terms
    svu5_q  <= (NW'(svu2_q) <<< 2) + NW'(svu2_q);
    svv5_q  <= (NW'(svv2_q) <<< 2) + NW'(svv2_q);
    svsu3_q <= sv2_q * su2_q;
    svsv3_q <= sv2_q * sv2_q;
    sv3_q   <= sv2_q;
    su3_q   <= su2_q;
    ch3_q   <= ch2_q;
    // stage 4: numerator and denominator
    num4_q <= svu5_q - NW'(svsu3_q);
    den4_q <= svv5_q - NW'(svsv3_q);
    sv4_q  <= sv3_q;
    su4_q  <= su3_q;
    ch4_q  <= ch3_q;
    // stage 5: magnitudes and overflow pre-check
    n_q   <= n_d;
    d_q   <= d_d;
    ctx_q <= ctx_d;
  end

  assign valid_o = vld_q[SUM_STAGES-1];
  assign n_o     = n_q;
  assign d_o     = d_q;
  assign ctx_o   = ctx_q;

endmodule

// File: rtl/core/lsf_div.sv
// Pipelined restoring divider: one quotient bit of n*2^17/d per stage.
module lsf_div import lsf_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [MW-1:0] n_i,
  input  logic [MW-1:0] d_i,
  input  ctx_t          ctx_i,
  output logic          valid_o,
  output logic [QB-1:0] q_o,
  output ctx_t          ctx_o
);

  logic [MW-1:0] rem_q [QB];
  logic [MW-1:0] den_q [QB];
  logic [QB-1:0] quo_q [QB];
  ctx_t          ctx_q [QB];
  logic [QB-1:0] vld_q;

  for (genvar g = 0; g < QB; g++) begin : g_stage
    logic [MW-1:0] rem_src, den_src, rem_d;
    logic [QB-1:0] quo_src;
    ctx_t          ctx_src;
    logic          vld_src, bit_d;

    if (g == 0) begin : g_first
      assign rem_src = n_i;
      assign den_src = d_i;
      assign quo_src = '0;
      assign ctx_src = ctx_i;
      assign vld_src = valid_i;
    end else begin : g_next
      assign rem_src = rem_q[g-1];
      assign den_src = den_q[g-1];
      assign quo_src = quo_q[g-1];
      assign ctx_src = ctx_q[g-1];
      assign vld_src = vld_q[g-1];
    end

    if (g < QI) begin : g_int
      // integer bits: compare against d shifted into place
      localparam int K = QI - 1 - g;
      logic [MW+QI-1:0] dk;
      assign dk    = {{QI{1'b0}}, den_src} << K;
      assign bit_d = ({{QI{1'b0}}, rem_src} >= dk);
      assign rem_d = bit_d ? (rem_src - dk[MW-1:0]) : rem_src;
    end else begin : g_frac
      logic [MW:0] r2, diff;
      assign r2    = {rem_src, 1'b0};
      assign diff  = r2 - {1'b0, den_src};
      assign bit_d = (r2 >= {1'b0, den_src});
      assign rem_d = bit_d ? diff[MW-1:0] : r2[MW-1:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else begin
        vld_q[g] <= vld_src;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[g] <= rem_d;
      den_q[g] <= den_src;
      quo_q[g] <= {quo_src[QB-2:0], bit_d};
      ctx_q[g] <= ctx_src;
    end
  end

  assign valid_o = vld_q[QB-1];
  assign q_o     = quo_q[QB-1];
  assign ctx_o   = ctx_q[QB-1];

endmodule

// File: rtl/core/lsf_icpt.sv
// Slope rounding and clamp, intercept numerator, divide by five, final clamp and status.
module lsf_icpt import lsf_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  logic [QB-1:0]         q_i,
  input  ctx_t                  ctx_i,
  output logic                  valid_o,
  output logic [CH_W-1:0]       channel_o,
  output logic signed [SLW-1:0] slope_o,
  output logic signed [SLW-1:0] intercept_o,
  output logic [1:0]            status_o
);

  localparam int XMW = XW - 1;
  localparam logic [QB-1:0]  M_NEG_LIM = QB'(1) << 31;
  localparam logic [QB-1:0]  M_POS_LIM = M_NEG_LIM - QB'(1);
  localparam logic [TW-1:0]  Q_NEG_LIM = TW'(1) << 31;
  localparam logic [TW-1:0]  Q_POS_LIM = Q_NEG_LIM - TW'(1);
  localparam logic [XMW:0]   RND_ADD   = (XMW+1)'(NPTS * 2048);
  localparam logic [XMW:0]   BIG_LIM   = ((XMW+1)'(NPTS) << 31) + (XMW+1)'(NPTS);

  typedef struct packed {
    logic [CH_W-1:0]  channel;
    logic [SLW-1:0]   slope;
    logic             sat;
    logic             degen;
    logic             xneg;
    logic             big;
  } side_t;

  logic [TAIL_STAGES-1:0] vld_q;

  // stage A
  logic [QB:0]           inc;
  logic [QB-1:0]         mag;
  logic signed [SLW-1:0] slope_a_d, slope_a_q;
  logic                  sat_a_d, sat_a_q;
  ctx_t                  ctx_a_q;
  // stage B
  logic signed [SLW+SW-1:0] prod_b_q;
  logic signed [SLW-1:0]    slope_b_q;
  logic                     sat_b_q;
  ctx_t                     ctx_b_q;
  // stage C
  logic signed [XW-1:0] x_c_q;
  side_t                side_c_q;
  // stage D
  logic [XMW-1:0] xmag_d_q;
  side_t          side_d_q;
  // stage E
  logic [XMW:0]   tsum, tval;
  logic [TW-1:0]  tt_e_q;
  side_t          side_e_q;
  // divide by five stages
  logic [TW-1:0]  dtt_q [DPS];
  logic [TW-1:0]  dquo_q [DPS];
  logic [2:0]     drem_q [DPS];
  side_t          dside_q [DPS];
  // final
  logic signed [SLW-1:0] icpt_d;
  logic                  sat_i_d;
  side_t                 fin_side;
  logic [TW-1:0]         fin_quo;
  logic [CH_W-1:0]       ch_q;
  logic signed [SLW-1:0] slope_q, icpt_q;
  logic [1:0]            status_q, status_d;

  assign inc = {1'b0, q_i} + (QB+1)'(1);
  assign mag = inc[QB:1];

  always_comb begin
    slope_a_d = '0;
    sat_a_d   = 1'b0;
    if (ctx_i.degen) begin
      slope_a_d = '0;
    end else if (ctx_i.ovf) begin
      sat_a_d   = 1'b1;
      slope_a_d = ctx_i.neg ? SAT_MIN : SAT_MAX;
    end else if (ctx_i.neg) begin
      if (mag > M_NEG_LIM) begin
        sat_a_d   = 1'b1;
        slope_a_d = SAT_MIN;
      end else begin
        slope_a_d = SLW'(-mag);
      end
    end else begin
      if (mag > M_POS_LIM) begin
        sat_a_d   = 1'b1;
        slope_a_d = SAT_MAX;
      end else begin
        slope_a_d = SLW'(mag);
      end
    end
  end

  assign tsum = {1'b0, xmag_d_q} + RND_ADD;
  assign tval = tsum >> RSH;

  for (genvar g = 0; g < DPS; g++) begin : g_div5
    logic [TW-1:0] tt_src, quo_src, quo_d, qv;
    logic [2:0]    rem_src, rem_d, rv;
    side_t         side_src;
    logic [6:0]    st;

    if (g == 0) begin : g_first
      assign tt_src   = tt_e_q;
      assign quo_src  = '0;
      assign rem_src  = '0;
      assign side_src = side_e_q;
    end else begin : g_next
      assign tt_src   = dtt_q[g-1];
      assign quo_src  = dquo_q[g-1];
      assign rem_src  = drem_q[g-1];
      assign side_src = dside_q[g-1];
    end

    // long division by five, one hex digit at a time, most significant first
    always_comb begin
      rv = rem_src;
      qv = quo_src;
      st = '0;
      for (int j = 0; j < DPS; j++) begin
        st = div5_step({rv, tt_src[4*(NDIG-1-g*DPS-j) +: 4]});
        qv[4*(NDIG-1-g*DPS-j) +: 4] = st[6:3];
        rv = st[2:0];
      end
      quo_d = qv;
      rem_d = rv;
    end

    always_ff @(posedge clk_i) begin
      dtt_q[g]   <= tt_src;
      dquo_q[g]  <= quo_d;
      drem_q[g]  <= rem_d;
      dside_q[g] <= side_src;
    end
  end

  assign fin_side = dside_q[DPS-1];
  assign fin_quo  = dquo_q[DPS-1];

  always_comb begin
    sat_i_d = 1'b0;
    icpt_d  = '0;
    if (fin_side.big) begin
      sat_i_d = 1'b1;
      icpt_d  = fin_side.xneg ? SAT_MIN : SAT_MAX;
    end else if (fin_side.xneg) begin
      if (fin_quo > Q_NEG_LIM) begin
        sat_i_d = 1'b1;
        icpt_d  = SAT_MIN;
      end else begin
        icpt_d  = SLW'(-fin_quo);
      end
    end else begin
      if (fin_quo > Q_POS_LIM) begin
        sat_i_d = 1'b1;
        icpt_d  = SAT_MAX;
      end else begin
        icpt_d  = SLW'(fin_quo);
      end
    end
    if (fin_side.degen) begin
      status_d = ST_DEGEN;
    end else if (fin_side.sat || sat_i_d) begin
      status_d = ST_SAT;
    end else begin
      status_d = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[TAIL_STAGES-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    // A
    slope_a_q <= slope_a_d;
    sat_a_q   <= sat_a_d;
    ctx_a_q   <= ctx_i;
    // B
    prod_b_q  <= slope_a_q * $signed(ctx_a_q.sv);
    slope_b_q <= slope_a_q;
    sat_b_q   <= sat_a_q;
    ctx_b_q   <= ctx_a_q;
    // C: x = Su*2^16 - slope*Sv
    x_c_q     <= (XW'($signed(ctx_b_q.su)) <<< FRAC) - XW'(prod_b_q);
    side_c_q  <= {ctx_b_q.channel, slope_b_q, sat_b_q, ctx_b_q.degen, 1'b0, 1'b0};
    // D
    xmag_d_q  <= x_c_q[XW-1] ? XMW'(-x_c_q) : XMW'(x_c_q);
    side_d_q  <= {side_c_q.channel, side_c_q.slope, side_c_q.sat, side_c_q.degen,
                  x_c_q[XW-1], side_c_q.big};
    // E
    tt_e_q    <= TW'(tval);
    side_e_q  <= {side_d_q.channel, side_d_q.slope, side_d_q.sat, side_d_q.degen,
                  side_d_q.xneg, (tval >= BIG_LIM)};
    // output register
    ch_q     <= fin_side.channel;
    slope_q  <= fin_side.slope;
    icpt_q   <= icpt_d;
    status_q <= status_d;
  end

  assign valid_o     = vld_q[TAIL_STAGES-1];
  assign channel_o   = ch_q;
  assign slope_o     = slope_q;
  assign intercept_o = icpt_q;
  assign status_o    = status_q;

endmodule

// File: rtl/core/least_squares_line_fit.sv
// Top level of the five-point least-squares line fit.
// A beat accepted with start runs through the sum, divider and tail stages to done_o.
// Throughput: one beat per cycle; busy is never raised, the pipeline never stalls.
// The rate is set by the 33-stage bit-per-stage divider, fully pipelined.
// Reset clears only the valid bits; payload registers are left as they are.
module least_squares_line_fit import lsf_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [CH_W-1:0]       channel_i,
  input  logic signed [VW-1:0]  volt_0_i,
  input  logic signed [VW-1:0]  volt_1_i,
  input  logic signed [VW-1:0]  volt_2_i,
  input  logic signed [VW-1:0]  volt_3_i,
  input  logic signed [VW-1:0]  volt_4_i,
  input  logic signed [VW-1:0]  unit_0_i,
  input  logic signed [VW-1:0]  unit_1_i,
  input  logic signed [VW-1:0]  unit_2_i,
  input  logic signed [VW-1:0]  unit_3_i,
  input  logic signed [VW-1:0]  unit_4_i,
  output logic                  done_o,
  output logic [CH_W-1:0]       out_channel_o,
  output logic signed [SLW-1:0] slope_o,
  output logic signed [SLW-1:0] intercept_o,
  output logic [1:0]            fit_status_o
);

  smp_t          volt [NPTS];
  smp_t          unit [NPTS];
  logic          accept;
  logic          sum_vld, div_vld;
  logic [MW-1:0] sum_n, sum_d;
  ctx_t          sum_ctx, div_ctx;
  logic [QB-1:0] div_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign volt[0] = volt_0_i;
  assign volt[1] = volt_1_i;
  assign volt[2] = volt_2_i;
  assign volt[3] = volt_3_i;
  assign volt[4] = volt_4_i;
  assign unit[0] = unit_0_i;
  assign unit[1] = unit_1_i;
  assign unit[2] = unit_2_i;
  assign unit[3] = unit_3_i;
  assign unit[4] = unit_4_i;

  lsf_sums u_sums (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (accept),
    .channel_i (channel_i),
    .volt_i    (volt),
    .unit_i    (unit),
    .valid_o   (sum_vld),
    .n_o       (sum_n),
    .d_o       (sum_d),
    .ctx_o     (sum_ctx)
  );

  lsf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sum_vld),
    .n_i     (sum_n),
    .d_i     (sum_d),
    .ctx_i   (sum_ctx),
    .valid_o (div_vld),
    .q_o     (div_q),
    .ctx_o   (div_ctx)
  );

  lsf_icpt u_icpt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (div_vld),
    .q_i         (div_q),
    .ctx_i       (div_ctx),
    .valid_o     (done_o),
    .channel_o   (out_channel_o),
    .slope_o     (slope_o),
    .intercept_o (intercept_o),
    .status_o    (fit_status_o)
  );

  // every result beat traces back to exactly one accepted beat
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, LAT))
    else $error("result beat without matching input beat");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (fit_status_o == ST_OK || fit_status_o == ST_DEGEN ||
                fit_status_o == ST_SAT))
    else $error("unknown fit status");

  a_degen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && fit_status_o == ST_DEGEN) |-> (slope_o == '0))
    else $error("degenerate fit with nonzero slope");

endmodule

// File: bench/tb_least_squares_line_fit.sv
// Testbench for the five-point least-squares line fit: directed and random point sets.
`timescale 1ns / 1ps

module tb_least_squares_line_fit;
  import lsf_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT  = LAT + 20;
  localparam longint unsigned ROUND_OFS = 64'd10240;  // half of 5 * 2^12
  localparam longint unsigned ICPT_DIV  = 64'd20480;  // 5 * 2^12

  typedef struct {
    logic [CH_W-1:0]       channel;
    logic signed [SLW-1:0] slope;
    logic signed [SLW-1:0] intercept;
    logic [1:0]            status;
  } fit_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  logic [CH_W-1:0]       channel_i;
  smp_t                  volt_0_i, volt_1_i, volt_2_i, volt_3_i, volt_4_i;
  smp_t                  unit_0_i, unit_1_i, unit_2_i, unit_3_i, unit_4_i;
  logic                  done_o;
  logic [CH_W-1:0]       out_channel_o;
  logic signed [SLW-1:0] slope_o;
  logic signed [SLW-1:0] intercept_o;
  logic [1:0]            fit_status_o;

  fit_t pending_fits[$];
  int   err_cnt;
  int   cyc_cnt;
  bit   gaps_on;

  least_squares_line_fit u_dut (
    .clk_i, .rst_ni, .start, .busy, .channel_i,
    .volt_0_i, .volt_1_i, .volt_2_i, .volt_3_i, .volt_4_i,
    .unit_0_i, .unit_1_i, .unit_2_i, .unit_3_i, .unit_4_i,
    .done_o, .out_channel_o, .slope_o, .intercept_o, .fit_status_o
  );

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  function automatic logic [SLW-1:0] clamp_q16(input bit neg, input longint unsigned mag,
                                               inout bit sat);
    if (neg) begin
      if (mag > 64'h8000_0000) begin
        sat = 1'b1;
        mag = 64'h8000_0000;
      end
      return SLW'(64'd0 - mag);
    end
    if (mag > 64'h7FFF_FFFF) begin
      sat = 1'b1;
      mag = 64'h7FFF_FFFF;
    end
    return SLW'(mag);
  endfunction

  function automatic fit_t predict_fit(input logic [CH_W-1:0] ch, input smp_t v[NPTS],
                                       input smp_t u[NPTS]);
    fit_t f;
    longint sv, su, svu, svv, num, den, x;
    longint unsigned n, d, q, r, mag;
    bit sat, neg;
    sv = 0; su = 0; svu = 0; svv = 0; sat = 1'b0;
    for (int i = 0; i < NPTS; i++) begin
      sv  += longint'(v[i]);
      su  += longint'(u[i]);
      svu += longint'(v[i]) * longint'(u[i]);
      svv += longint'(v[i]) * longint'(v[i]);
    end
    num = 5 * svu - sv * su;
    den = 5 * svv - sv * sv;
    f.channel = ch;
    f.slope   = '0;
    if (den > 0) begin
      neg = num < 0;
      n = neg ? 64'd0 - longint'(num) : num;
      d = den;
      q = n / d;
      r = n % d;
      if (q >= 64'd65536) begin
        mag = 64'd1 << 40;  // far out of range, saturates below
      end else begin
        for (int i = 0; i < FRAC; i++) begin
          r = r << 1;
          q = q << 1;
          if (r >= d) begin
            r -= d;
            q |= 64'd1;
          end
        end
        if ((r << 1) >= d) q += 1;
        mag = q;
      end
      f.slope = clamp_q16(neg, mag, sat);
    end
    x = su * 65536 - longint'(f.slope) * sv;
    mag = (x < 0) ? 64'd0 - longint'(x) : x;
    mag = (mag + ROUND_OFS) / ICPT_DIV;
    f.intercept = clamp_q16(x < 0, mag, sat);
    f.status = (den <= 0) ? ST_DEGEN : (sat ? ST_SAT : ST_OK);
    return f;
  endfunction

  // one beat: hold start until busy is low at an edge, then maybe idle a while
  task automatic send_fit(input logic [CH_W-1:0] ch, input smp_t v[NPTS], input smp_t u[NPTS]);
    channel_i <= ch;
    volt_0_i <= v[0]; volt_1_i <= v[1]; volt_2_i <= v[2]; volt_3_i <= v[3]; volt_4_i <= v[4];
    unit_0_i <= u[0]; unit_1_i <= u[1]; unit_2_i <= u[2]; unit_3_i <= u[3]; unit_4_i <= u[4];
    start <= 1'b1;
    @(negedge clk_i);
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
    pending_fits.push_back(predict_fit(ch, v, u));
    if (gaps_on && $urandom_range(0, 99) < 15) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic idle_until_drained();
    start <= 1'b0;
    while (pending_fits.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  function automatic smp_t clip24(input longint val);
    if (val > 64'sd8388607) return smp_t'(24'h7FFFFF);
    if (val < -64'sd8388608) return smp_t'(24'h800000);
    return smp_t'(val);
  endfunction

  task automatic test_extremes();
    smp_t v[NPTS], u[NPTS];
    smp_t ext[5];
    ext = '{smp_t'(24'h7FFFFF), smp_t'(24'h800000), smp_t'(0), smp_t'(1), smp_t'(-1)};
    foreach (v[i]) begin v[i] = ext[0]; u[i] = ext[0]; end
    send_fit(4'd0, v, u);
    foreach (v[i]) begin v[i] = ext[1]; u[i] = ext[1]; end
    send_fit(4'd15, v, u);
    // alternating full-scale voltages, readings at the opposite extreme
    foreach (v[i]) begin v[i] = ext[i % 2]; u[i] = ext[(i + 1) % 2]; end
    send_fit(4'd5, v, u);
    foreach (v[i]) begin v[i] = ext[i]; u[i] = ext[4 - i]; end
    send_fit(4'd10, v, u);
    foreach (v[i]) begin v[i] = smp_t'(i * 4096); u[i] = smp_t'(i * 8192 + 4096); end
    send_fit(4'd3, v, u);
    foreach (v[i]) begin v[i] = smp_t'(i - 2); u[i] = smp_t'(-3 * (i - 2)); end
    send_fit(4'd7, v, u);
  endtask

  task automatic test_degenerate();
    smp_t v[NPTS], u[NPTS];
    foreach (v[i]) begin v[i] = '0; u[i] = '0; end
    send_fit(4'd1, v, u);
    foreach (v[i]) begin v[i] = smp_t'(24'h7FFFFF); u[i] = smp_t'(24'h7FFFFF); end
    send_fit(4'd2, v, u);
    foreach (v[i]) begin v[i] = smp_t'(24'h800000); u[i] = smp_t'(24'h800000); end
    send_fit(4'd4, v, u);
    foreach (v[i]) begin v[i] = smp_t'(12345); u[i] = smp_t'(i * 3 - 7); end
    send_fit(4'd6, v, u);
  endtask

  task automatic test_saturation();
    smp_t v[NPTS], u[NPTS];
    // one LSB voltage step with full-scale readings: slope far out of range
    foreach (v[i]) begin
      v[i] = smp_t'(i);
      u[i] = (i < 2) ? smp_t'(24'h800000) : smp_t'(24'h7FFFFF);
    end
    send_fit(4'd8, v, u);
    foreach (v[i]) begin
      v[i] = smp_t'(i);
      u[i] = (i < 2) ? smp_t'(24'h7FFFFF) : smp_t'(24'h800000);
    end
    send_fit(4'd9, v, u);
    // slope in range, intercept pushed out by a large offset voltage
    foreach (v[i]) begin v[i] = smp_t'(24'h7FFF00 + i); u[i] = smp_t'(i * 1000); end
    send_fit(4'd11, v, u);
    foreach (v[i]) begin v[i] = smp_t'(-8388608 + i * 2); u[i] = smp_t'(-i * 30000); end
    send_fit(4'd12, v, u);
    idle_until_drained();
  endtask

  task automatic test_random(input int count);
    smp_t v[NPTS], u[NPTS];
    int   kind, k;
    longint base, offs;
    for (int n = 0; n < count; n++) begin
      gaps_on = !(n >= 300 && n < 500);
      kind = $urandom_range(0, 99);
      base = longint'(smp_t'($urandom));
      k    = int'($urandom_range(0, 32)) - 16;
      offs = longint'(smp_t'($urandom)) >>> $urandom_range(0, 12);
      for (int i = 0; i < NPTS; i++) begin
        if (kind < 25) begin
          v[i] = smp_t'($urandom);
          u[i] = smp_t'($urandom);
        end else if (kind < 55) begin
          // noisy line through spread voltages
          v[i] = clip24((base >>> 4) + longint'(int'($urandom_range(0, 1 << 18)) - (1 << 17)));
          u[i] = clip24(longint'(k) * longint'(v[i]) / 4 + offs
                        + longint'(int'($urandom_range(0, 64)) - 32));
        end else if (kind < 65) begin
          v[i] = smp_t'(base);
          u[i] = smp_t'($urandom);
        end else if (kind < 85) begin
          // tight voltage cluster: steep slopes and saturation
          v[i] = clip24(base + longint'($urandom_range(0, 3)));
          u[i] = smp_t'($urandom);
        end else begin
          case ($urandom_range(0, 4))
            0: v[i] = smp_t'(24'h7FFFFF);
            1: v[i] = smp_t'(24'h800000);
            2: v[i] = smp_t'(0);
            3: v[i] = smp_t'(-1);
            default: v[i] = smp_t'($urandom);
          endcase
          u[i] = ($urandom_range(0, 1) != 0)
                 ? smp_t'(24'h7FFFFF) ^ smp_t'($urandom_range(0, 1) << 23)
                 : smp_t'($urandom);
        end
      end
      send_fit(CH_W'($urandom), v, u);
      if (n == 600) idle_until_drained();
    end
  endtask

  always @(posedge clk_i) begin
    fit_t exp_fit;
    if (rst_ni && done_o) begin
      if (pending_fits.size() == 0) begin
        $error("unexpected result: channel %0d", out_channel_o);
        err_cnt++;
      end else begin
        exp_fit = pending_fits.pop_front();
        if (out_channel_o !== exp_fit.channel) begin
          $error("out_channel exp %0d got %0d", exp_fit.channel, out_channel_o);
          err_cnt++;
        end
        if (slope_o !== exp_fit.slope) begin
          $error("slope exp %0d got %0d", exp_fit.slope, slope_o);
          err_cnt++;
        end
        if (intercept_o !== exp_fit.intercept) begin
          $error("intercept exp %0d got %0d", exp_fit.intercept, intercept_o);
          err_cnt++;
        end
        if (fit_status_o !== exp_fit.status) begin
          $error("fit_status exp %0d got %0d", exp_fit.status, fit_status_o);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    err_cnt = 0;
    cyc_cnt = 0;
    gaps_on = 1'b1;
    rst_ni = 1'b0;
    start = 1'b0;
    channel_i = '0;
    {volt_0_i, volt_1_i, volt_2_i, volt_3_i, volt_4_i} = '0;
    {unit_0_i, unit_1_i, unit_2_i, unit_3_i, unit_4_i} = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_degenerate();
    test_saturation();
    test_random(950);
    start <= 1'b0;
    while (pending_fits.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
